[rtl/core/swhk_pkg.sv]
// ----------------------------------------------------------------------------
// swhk_pkg
// shared widths, codes, controller states and command/status bundles for the
// sliding window hot key detector
// ----------------------------------------------------------------------------
package swhk_pkg;

   // field widths
   localparam int TIME_W     = 32;
   localparam int KEY_W      = 16;
   localparam int COUNT_W    = 13;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // default sizes
   localparam int DEF_WINDOW_DEPTH = 4096;
   localparam int DEF_KEY_SPACE    = 65536;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SPAN   = 4'd0,
      CSR_HOT_THRESHOLD = 4'd1
   } csr_index_type;

   // per key entry of the count memory
   typedef struct packed {
      logic               hot;
      logic [COUNT_W-1:0] count;
   } cnt_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT_MUL,
      ST_SLOT_FIX,
      ST_CNT_RD,
      ST_CNT_GET,
      ST_OV_DEC,
      ST_APPEND,
      ST_EV_RDQ,
      ST_EV_CHK,
      ST_EV_DEC,
      ST_FINISH
   } swhk_state_type;

   // controller to datapath
   typedef struct packed {
      logic req_ready;
      logic clr_wr;
      logic slot_mul;
      logic slot_fix;
      logic rd_cur;
      logic q_rd;
      logic load_cur;
      logic dec_cur;
      logic inc_cur;
      logic rd_old;
      logic wr_old;
      logic pop;
      logic push;
      logic finish;
   } swhk_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic clr_done;
      logic full;
      logic fill_gt1;
      logic same_slot;
      logic expire;
      logic out_free;
   } swhk_status_type;

   function automatic logic [COUNT_W-1:0] cnt_dec(input logic [COUNT_W-1:0] c);
      cnt_dec = (c == '0) ? c : c - COUNT_W'(1);
   endfunction

   function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] c);
      cnt_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

[rtl/core/swhk_req_if.sv]
// ----------------------------------------------------------------------------
// swhk_req_if
// event channel: timestamp and key with valid/ready
// ----------------------------------------------------------------------------
interface swhk_req_if
   import swhk_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] event_time;
   logic [KEY_W-1:0]  post_key;

   modport source (output valid, output event_time, output post_key, input ready);
   modport sink   (input valid, input event_time, input post_key, output ready);
endinterface

[rtl/core/swhk_rsp_if.sv]
// ----------------------------------------------------------------------------
// swhk_rsp_if
// result channel: per event key count and hot flags with valid/ready
// ----------------------------------------------------------------------------
interface swhk_rsp_if
   import swhk_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [KEY_W-1:0]   result_key;
   logic [COUNT_W-1:0] window_count;
   logic               is_hot;
   logic               newly_hot;
   logic               overflow;

   modport source (output valid, output result_key, output window_count,
                   output is_hot, output newly_hot, output overflow, input ready);
   modport sink   (input valid, input result_key, input window_count,
                   input is_hot, input newly_hot, input overflow, output ready);
endinterface

[rtl/core/swhk_csr_if.sv]
// ----------------------------------------------------------------------------
// swhk_csr_if
// register write channel: index and data with valid/ready
// ----------------------------------------------------------------------------
interface swhk_csr_if
   import swhk_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/sliding_window_hot_key_detector.sv]
// ----------------------------------------------------------------------------
// sliding_window_hot_key_detector
// per key event count over a sliding time window with a sticky hot mark
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   req_if    in         valid / ready    event_time[31:0], post_key[15:0]
//   rsp_if    out        valid / ready    result_key[15:0], window_count[12:0],
//                                         is_hot, newly_hot, overflow
//   csr_if    in         valid / ready    index[3:0], data[31:0]
//
// an event runs from its request transaction through the slot reduction
// (multiply, then fix), the count read and load, a forced eviction of an entry
// of another key when the queue is full, the append, and the sweep: one queue
// read per expired entry, plus a count memory read and write for an entry of
// another key, until only the new event is left or the oldest has not expired;
// the cost is set by the read-modify-write on the count memory and one queue
// read per eviction step; the next request transaction is taken in the idle
// state after the result is loaded; after reset the count memory is swept to
// zero with req_if.ready low; csr writes are taken at any time
// the result sits in an output register, so a new request transaction is
// taken while a result waits; a stalled rsp_if holds the next event at its end
//
module sliding_window_hot_key_detector
   import swhk_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int KEY_SPACE    = DEF_KEY_SPACE
) (
   input  logic       clock,
   input  logic       reset,
   swhk_req_if.sink   req_if,
   swhk_rsp_if.source rsp_if,
   swhk_csr_if.sink   csr_if
);
   // command and status between sequencer and datapath
   swhk_cmd_type    cmd;
   swhk_status_type status;

   // sequencer: clear sweep, then per event steps
   swhk_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // datapath: event queue, count memory, registers and result register
   swhk_dpath #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .KEY_SPACE    (KEY_SPACE)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status),
      .req    (req_if),
      .rsp    (rsp_if),
      .csr    (csr_if)
   );
endmodule

[rtl/core/swhk_ram.sv]
// ----------------------------------------------------------------------------
// swhk_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module swhk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/core/swhk_ctrl.sv]
// ----------------------------------------------------------------------------
// swhk_ctrl
// sequencer: clear sweep, slot reduction, count update, eviction loop, result
// ----------------------------------------------------------------------------
module swhk_ctrl
   import swhk_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  swhk_status_type status,
   output swhk_cmd_type    cmd
);
   swhk_state_type state_ff;
   swhk_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               state_in = ST_SLOT_MUL;
            end
         end
         ST_SLOT_MUL: begin
            cmd.slot_mul = 1'b1;
            state_in     = ST_SLOT_FIX;
         end
         ST_SLOT_FIX: begin
            cmd.slot_fix = 1'b1;
            state_in     = ST_CNT_RD;
         end
         ST_CNT_RD: begin
            cmd.rd_cur = 1'b1;
            cmd.q_rd   = 1'b1;
            state_in   = ST_CNT_GET;
         end
         ST_CNT_GET: begin
            cmd.load_cur = 1'b1;
            if (!status.full) begin
               state_in = ST_APPEND;
            end else if (status.same_slot) begin
               cmd.dec_cur = 1'b1;
               cmd.pop     = 1'b1;
               state_in    = ST_APPEND;
            end else begin
               cmd.rd_old = 1'b1;
               state_in   = ST_OV_DEC;
            end
         end
         ST_OV_DEC: begin
            cmd.wr_old = 1'b1;
            cmd.pop    = 1'b1;
            state_in   = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.push    = 1'b1;
            cmd.inc_cur = 1'b1;
            state_in    = ST_EV_RDQ;
         end
         ST_EV_RDQ: begin
            if (status.fill_gt1) begin
               cmd.q_rd = 1'b1;
               state_in = ST_EV_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EV_CHK: begin
            if (!status.expire) begin
               state_in = ST_FINISH;
            end else if (status.same_slot) begin
               cmd.dec_cur = 1'b1;
               cmd.pop     = 1'b1;
               state_in    = ST_EV_RDQ;
            end else begin
               cmd.rd_old = 1'b1;
               state_in   = ST_EV_DEC;
            end
         end
         ST_EV_DEC: begin
            cmd.wr_old = 1'b1;
            cmd.pop    = 1'b1;
            state_in   = ST_EV_RDQ;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end
endmodule

[rtl/core/swhk_dpath.sv]
// ----------------------------------------------------------------------------
// swhk_dpath
// datapath: registers, event queue, per key count memory, output register
// ----------------------------------------------------------------------------
module swhk_dpath
   import swhk_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int KEY_SPACE    = DEF_KEY_SPACE
) (
   input  logic            clock,
   input  logic            reset,
   input  swhk_cmd_type    cmd,
   output swhk_status_type status,
   swhk_req_if.sink        req,
   swhk_rsp_if.source      rsp,
   swhk_csr_if.sink        csr
);
   localparam int QW   = $clog2(WINDOW_DEPTH);
   localparam int FW   = $clog2(WINDOW_DEPTH + 1);
   localparam int KW   = $clog2(KEY_SPACE);
   localparam int QE_W = TIME_W + KW;
   localparam int CE_W = $bits(cnt_entry_type);

   // exact reciprocal reduction of a 16 bit key by the key space
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << 32) + longint'(KEY_SPACE) - 64'd1) / longint'(KEY_SPACE);
   localparam logic [31:0]     RECIP   = 32'(RECIP_FULL);
   localparam logic [KEY_W-1:0] KS_LOW = KEY_W'(KEY_SPACE % 65536);
   localparam bit              KEY_FITS = (KEY_SPACE >= 65536);

   // configuration
   logic [TIME_W-1:0]  span_ff;
   logic [COUNT_W-1:0] thr_ff;

   // current event
   logic [TIME_W-1:0]  now_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [47:0]        prod_ff;
   logic [KW-1:0]      slot_ff;
   logic [COUNT_W-1:0] cur_count_ff;
   logic [COUNT_W-1:0] cur_count_in;
   logic               cur_hot_ff;
   logic               ovf_ff;

   // queue control
   logic [QW-1:0]      head_ff;
   logic [QW-1:0]      head_in;
   logic [FW-1:0]      fill_ff;
   logic [FW-1:0]      fill_in;
   logic [KW-1:0]      clr_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_hot_ff;
   logic               rsp_newly_ff;
   logic               rsp_ovf_ff;

   // memory ports
   logic [QE_W-1:0]    q_rd_data;
   logic [QE_W-1:0]    q_wr_data;
   logic [QW-1:0]      tail;
   logic [FW:0]        tail_sum;
   logic [TIME_W-1:0]  q_time;
   logic [KW-1:0]      q_slot;
   cnt_entry_type      c_rd_data;
   cnt_entry_type      c_wr_data;
   logic [CE_W-1:0]    c_rd_raw;
   logic [KW-1:0]      c_rd_addr;
   logic [KW-1:0]      c_wr_addr;
   logic               c_wr_en;

   // slot reduction
   logic [KEY_W-1:0]   quo;
   logic [KEY_W-1:0]   quo_k;
   logic [KEY_W-1:0]   rem;
   logic [31:0]        slot_wide;

   logic [COUNT_W-1:0] c_base;
   logic [COUNT_W-1:0] c_dec;
   logic               newly;
   logic               req_take;

   assign req.ready = cmd.req_ready;
   assign req_take  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff <= TIME_W'(1);
         thr_ff  <= COUNT_W'(1);
      end else if (csr.valid) begin
         unique case (csr_index_type'(csr.index))
            CSR_WINDOW_SPAN:   span_ff <= csr.data;
            CSR_HOT_THRESHOLD: thr_ff  <= csr.data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // slot = key mod key space
   assign quo       = prod_ff[47:32];
   assign quo_k     = KEY_W'(quo * KS_LOW);
   assign rem       = key_ff - quo_k;
   assign slot_wide = KEY_FITS ? 32'(key_ff) : 32'(rem);

   // queue entry fields
   assign q_time = q_rd_data[QE_W-1 -: TIME_W];
   assign q_slot = q_rd_data[KW-1:0];
   assign c_rd_data = cnt_entry_type'(c_rd_raw);

   // tail = (head + fill) mod depth, sum stays below twice the depth
   assign tail_sum = (FW+1)'(head_ff) + (FW+1)'(fill_ff);
   always_comb begin
      if (tail_sum >= (FW+1)'(WINDOW_DEPTH)) begin
         tail = QW'(tail_sum - (FW+1)'(WINDOW_DEPTH));
      end else begin
         tail = QW'(tail_sum);
      end
   end
   assign q_wr_data = {now_ff, slot_ff};

   // count of the current key, kept in a register until the result
   always_comb begin
      c_base       = cmd.load_cur ? c_rd_data.count : cur_count_ff;
      c_dec        = cmd.dec_cur ? cnt_dec(c_base) : c_base;
      cur_count_in = cmd.inc_cur ? cnt_inc(c_dec) : c_dec;
   end

   assign newly = (cur_count_ff >= thr_ff) && !cur_hot_ff;

   // head and fill
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.pop) begin
         head_in = (head_ff == QW'(WINDOW_DEPTH - 1)) ? '0 : head_ff + QW'(1);
         fill_in = fill_ff - FW'(1);
      end else if (cmd.push) begin
         fill_in = fill_ff + FW'(1);
      end
   end

   // count memory ports
   always_comb begin
      c_rd_addr = cmd.rd_old ? q_slot : slot_ff;
      c_wr_en   = cmd.clr_wr || cmd.wr_old || cmd.finish;
      c_wr_addr = slot_ff;
      c_wr_data = '0;
      if (cmd.clr_wr) begin
         c_wr_addr = clr_ff;
      end else if (cmd.wr_old) begin
         c_wr_addr       = q_slot;
         c_wr_data.hot   = c_rd_data.hot;
         c_wr_data.count = cnt_dec(c_rd_data.count);
      end else begin
         c_wr_data.hot   = cur_hot_ff || newly;
         c_wr_data.count = cur_count_ff;
      end
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         fill_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.clr_wr) begin
            clr_ff <= clr_ff + KW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff <= req.event_time;
         key_ff <= req.post_key;
      end
      if (cmd.slot_mul) begin
         prod_ff <= 48'(key_ff) * 48'(RECIP);
      end
      if (cmd.slot_fix) begin
         slot_ff <= slot_wide[KW-1:0];
      end
      cur_count_ff <= cur_count_in;
      if (cmd.load_cur) begin
         cur_hot_ff <= c_rd_data.hot;
         ovf_ff     <= status.full;
      end
      if (cmd.finish) begin
         rsp_key_ff   <= key_ff;
         rsp_count_ff <= cur_count_ff;
         rsp_hot_ff   <= cur_hot_ff || newly;
         rsp_newly_ff <= newly;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_key   = rsp_key_ff;
   assign rsp.window_count = rsp_count_ff;
   assign rsp.is_hot       = rsp_hot_ff;
   assign rsp.newly_hot    = rsp_newly_ff;
   assign rsp.overflow     = rsp_ovf_ff;

   // status
   assign status.req_valid = req.valid;
   assign status.clr_done  = (clr_ff == KW'(KEY_SPACE - 1));
   assign status.full      = (fill_ff == FW'(WINDOW_DEPTH));
   assign status.fill_gt1  = (fill_ff > FW'(1));
   assign status.same_slot = (q_slot == slot_ff);
   assign status.expire    = (q_time <= now_ff) && ((now_ff - q_time) >= span_ff);
   assign status.out_free  = !rsp_valid_ff || rsp.ready;

   swhk_ram #(
      .WIDTH (QE_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail),
      .wr_data (q_wr_data),
      .rd_en   (cmd.q_rd),
      .rd_addr (head_ff),
      .rd_data (q_rd_data)
   );

   swhk_ram #(
      .WIDTH (CE_W),
      .DEPTH (KEY_SPACE)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_en   (cmd.rd_cur || cmd.rd_old),
      .rd_addr (c_rd_addr),
      .rd_data (c_rd_raw)
   );
endmodule

[rtl/core/swhk_checker.sv]
// ----------------------------------------------------------------------------
// swhk_checker
// port level checks of the hot key detector, bound to the top level
// ----------------------------------------------------------------------------
module swhk_checker
   import swhk_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic [KEY_W-1:0] req_post_key,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [KEY_W-1:0] rsp_result_key,
   input logic             rsp_is_hot,
   input logic             rsp_newly_hot
);
   logic [1:0]       open_ff;
   logic [1:0]       open_in;
   logic [KEY_W-1:0] last_key_ff;
   logic             req_take;
   logic             rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (req_take && !rsp_take) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_take && !req_take) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         last_key_ff <= req_post_key;
      end
   end

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_key))
      else $error("result changed while stalled");

   // no result without an open event
   a_rsp_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result without a request");

   // a fresh result carries the key of the latest event
   a_rsp_key: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_result_key == last_key_ff)
      else $error("result key mismatch");

   // newly hot implies hot
   a_newly_hot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_newly_hot |-> rsp_is_hot)
      else $error("newly hot without hot");

   // clear sweep keeps requests out right after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clear");
endmodule

bind sliding_window_hot_key_detector swhk_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_post_key   (req_if.post_key),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_result_key (rsp_if.result_key),
   .rsp_is_hot     (rsp_if.is_hot),
   .rsp_newly_hot  (rsp_if.newly_hot)
);
